### rtl/psq_pkg.sv
package psq_pkg;

  // Result kinds carried on the output side
  typedef enum logic [1:0] {
    CODE_FRESH     = 2'd0,
    CODE_HELD      = 2'd1,
    CODE_REJECT    = 2'd2,
    CODE_BUS_ERROR = 2'd3
  } psq_code_t;

  // Configuration register indexes
  localparam logic CFG_PRESSURE_LOW  = 1'b0;
  localparam logic CFG_PRESSURE_HIGH = 1'b1;

  localparam logic signed [20:0] PRESSURE_LOW_RESET  = 21'sd0;
  localparam logic signed [20:0] PRESSURE_HIGH_RESET = 21'sd100000;

  // Frame acceptance limits
  localparam logic [23:0] SPAN_LO         = 24'd1677722;
  localparam logic [23:0] SPAN_HI         = 24'd15099494;
  localparam logic [7:0]  BAD_STATUS_MASK = 8'h25;
  localparam logic [23:0] TEAR_LIMIT      = 24'd1024;

  // One read attempt: two sensor frames
  typedef struct packed {
    logic [7:0]  first_status;
    logic [23:0] first_pressure;
    logic [23:0] first_temperature;
    logic        first_ok;
    logic [7:0]  second_status;
    logic [23:0] second_pressure;
    logic        second_ok;
  } psq_item_t;

  // One qualified sample
  typedef struct packed {
    psq_code_t          code;
    logic [7:0]         status_byte;
    logic [23:0]        raw_pressure_out;
    logic [23:0]        raw_temperature_out;
    logic signed [20:0] pressure_pa;
    logic signed [14:0] temperature_centi;
    logic               held_flag;
    logic [31:0]        fresh_count;
    logic [31:0]        fault_count;
    logic [31:0]        hold_count;
  } psq_result_t;

endpackage

### rtl/pressure_sample_qualifier_core.sv
// Pressure sample qualifier.
// Input stream (s_*): one item per read attempt, two sensor frames with their
// bus-ok flags. Output stream (m_*): one qualified sample per input item, in
// order: fresh, held last good, rejected with no good sample, or bus error,
// with the raw values, the converted pressure (Pa) and temperature (0.01 C)
// and three wrapping 32-bit event counters.
// An item passes the input register and then the result register before
// m_tvalid goes up, so a result is never taken in the cycle its item is accepted.
// One item is accepted every cycle when the output side does not stall; the path
// between the registers is a single 28x22 signed multiply plus round and add.
// The output register advances when it is empty or taken, and the input
// register advances with it, so a stalled receiver stops intake after the two
// registers fill; no item is dropped.
// Configuration (cfg_*): index 0 is the pressure at 10 % of the raw span,
// index 1 the pressure at 90 %, both 21-bit signed; write only while idle.
// Reset (rst, synchronous) empties both registers, clears the stored sample,
// the held flag and the counters, and loads the default calibration
// (0 Pa and 100000 Pa).
module pressure_sample_qualifier_core
  import psq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // first_status, first_pressure, first_temperature,
                                // second_status, second_pressure
  input  logic [1:0]  s_tuser,  // first_ok, second_ok
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [191:0] m_tdata, // status_byte, raw_pressure_out, raw_temperature_out,
                                // pressure_pa, temperature_centi, fresh_count,
                                // fault_count, hold_count, zero fill
  output logic [2:0]  m_tuser,  // result_code, held_flag
  // Configuration writes
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [20:0] cfg_wdata
);

  logic               in_valid;
  psq_item_t          in_item;
  logic               out_valid;
  psq_result_t        out_result;
  psq_result_t        result_next;
  logic               advance;
  logic               load;
  logic signed [20:0] pressure_low;
  logic signed [20:0] pressure_high;

  assign advance  = !out_valid || m_tready;
  assign load     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_low  <= PRESSURE_LOW_RESET;
      pressure_high <= PRESSURE_HIGH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_PRESSURE_LOW:  pressure_low  <= cfg_wdata;
        CFG_PRESSURE_HIGH: pressure_high <= cfg_wdata;
        default:           pressure_low  <= pressure_low;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.first_status      <= s_tdata[7:0];
      in_item.first_pressure    <= s_tdata[31:8];
      in_item.first_temperature <= s_tdata[55:32];
      in_item.first_ok          <= s_tuser[0];
      in_item.second_status     <= s_tdata[63:56];
      in_item.second_pressure   <= s_tdata[87:64];
      in_item.second_ok         <= s_tuser[1];
    end
  end

  psq_qualify u_qualify (
    .clk           (clk),
    .rst           (rst),
    .item          (in_item),
    .load          (load),
    .pressure_low  (pressure_low),
    .pressure_high (pressure_high),
    .result        (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0,
                     out_result.hold_count,
                     out_result.fault_count,
                     out_result.fresh_count,
                     out_result.temperature_centi,
                     out_result.pressure_pa,
                     out_result.raw_temperature_out,
                     out_result.raw_pressure_out,
                     out_result.status_byte};
  assign m_tuser  = {out_result.held_flag, out_result.code};

  // Intake never stalls while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result register");

  // An item leaving the input register shows up as a result next cycle
  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("loaded item not presented");

  // A waiting input item is kept while the output side stalls
  a_input_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("input item lost during stall");

  // A fresh sample always clears the held flag it reports
  a_fresh_not_held: assert property (@(posedge clk) disable iff (rst)
    (load && result_next.code == CODE_FRESH) |=> !m_tuser[2])
    else $error("fresh sample reported as held");

endmodule

### rtl/psq_convert.sv
module psq_convert
  import psq_pkg::*;
(
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  input  logic signed [20:0] pressure_low,
  input  logic signed [20:0] pressure_high,
  output logic signed [20:0] pressure_pa,
  output logic signed [14:0] temperature_centi
);

  localparam logic [27:0]        SPAN_OFFSET = 28'd16777216;
  localparam logic signed [49:0] ROUND_HALF  = 50'sd67108864;
  localparam logic [14:0]        TEMP_SCALE  = 15'd16500;
  localparam logic [14:0]        TEMP_OFFSET = 15'd4000;

  logic [27:0]        raw_times_ten;
  logic [27:0]        span_num;
  logic signed [21:0] span_diff;
  logic signed [49:0] product;
  logic signed [49:0] rounded;
  logic signed [22:0] scaled;
  logic signed [22:0] pressure_sum;
  logic [38:0]        temp_product;

  // Pressure: low + round((10*raw - 2^24) * (high - low) / 2^27)
  // An accepted raw value keeps the numerator below 2^27 and non-negative.
  assign raw_times_ten = ({4'd0, raw_pressure} << 3) + ({4'd0, raw_pressure} << 1);
  assign span_num      = raw_times_ten - SPAN_OFFSET;
  assign span_diff     = 22'(pressure_high) - 22'(pressure_low);
  assign product       = 50'(signed'({1'b0, span_num[26:0]})) * 50'(span_diff);
  assign rounded       = product + ROUND_HALF;
  assign scaled        = rounded[49:27];
  assign pressure_sum  = scaled + 23'(pressure_low);
  assign pressure_pa   = pressure_sum[20:0];

  // Temperature: floor(raw * 16500 / 2^24) - 4000
  assign temp_product      = {15'd0, raw_temperature} * {24'd0, TEMP_SCALE};
  assign temperature_centi = signed'(temp_product[38:24] - TEMP_OFFSET);

endmodule

### rtl/psq_qualify.sv
module psq_qualify
  import psq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  psq_item_t          item,
  input  logic               load,
  input  logic signed [20:0] pressure_low,
  input  logic signed [20:0] pressure_high,
  output psq_result_t        result
);

  logic               have_good;
  logic [23:0]        good_raw_pressure;
  logic [23:0]        good_raw_temperature;
  logic signed [20:0] good_pressure;
  logic signed [14:0] good_temperature;
  logic               held_state;
  logic [31:0]        accepted_total;
  logic [31:0]        bus_error_total;
  logic [31:0]        held_total;

  logic               held_state_next;
  logic [31:0]        accepted_total_next;
  logic [31:0]        bus_error_total_next;
  logic [31:0]        held_total_next;

  logic               first_bad;
  logic               second_bad;
  logic [23:0]        tear;
  logic               hold;
  logic               fresh;
  logic signed [20:0] conv_pressure;
  logic signed [14:0] conv_temperature;

  function automatic logic frame_bad(input logic [7:0] status, input logic [23:0] raw);
    frame_bad = ((status & BAD_STATUS_MASK) != 8'd0) || (raw < SPAN_LO) || (raw > SPAN_HI);
  endfunction

  psq_convert u_convert (
    .raw_pressure      (item.first_pressure),
    .raw_temperature   (item.first_temperature),
    .pressure_low      (pressure_low),
    .pressure_high     (pressure_high),
    .pressure_pa       (conv_pressure),
    .temperature_centi (conv_temperature)
  );

  // Check both frames and the tear between them
  assign first_bad  = frame_bad(item.first_status, item.first_pressure);
  assign second_bad = frame_bad(item.second_status, item.second_pressure);
  assign tear       = (item.first_pressure > item.second_pressure)
                    ? item.first_pressure - item.second_pressure
                    : item.second_pressure - item.first_pressure;
  assign hold       = first_bad || !item.second_ok || second_bad || (tear > TEAR_LIMIT);
  assign fresh      = item.first_ok && !hold;

  // Build the result and the next counter values
  always_comb begin
    held_state_next      = held_state;
    accepted_total_next  = accepted_total;
    bus_error_total_next = bus_error_total;
    held_total_next      = held_total;
    result               = '0;
    result.code          = CODE_BUS_ERROR;

    if (!item.first_ok) begin
      bus_error_total_next = bus_error_total + 32'd1;
    end else begin
      result.status_byte = item.first_status;
      if (!first_bad && !item.second_ok) begin
        bus_error_total_next = bus_error_total + 32'd1;
      end
      if (hold) begin
        held_state_next = 1'b1;
        held_total_next = held_total + 32'd1;
        if (have_good) begin
          result.code                = CODE_HELD;
          result.raw_pressure_out    = good_raw_pressure;
          result.raw_temperature_out = good_raw_temperature;
          result.pressure_pa         = good_pressure;
          result.temperature_centi   = good_temperature;
        end else begin
          result.code = CODE_REJECT;
        end
      end else begin
        held_state_next            = 1'b0;
        accepted_total_next        = accepted_total + 32'd1;
        result.code                = CODE_FRESH;
        result.raw_pressure_out    = item.first_pressure;
        result.raw_temperature_out = item.first_temperature;
        result.pressure_pa         = conv_pressure;
        result.temperature_centi   = conv_temperature;
      end
    end

    result.held_flag   = held_state_next;
    result.fresh_count = accepted_total_next;
    result.fault_count = bus_error_total_next;
    result.hold_count  = held_total_next;
  end

  // Advance the qualifier state as each item leaves for the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      have_good       <= 1'b0;
      held_state      <= 1'b0;
      accepted_total  <= '0;
      bus_error_total <= '0;
      held_total      <= '0;
    end else if (load) begin
      held_state      <= held_state_next;
      accepted_total  <= accepted_total_next;
      bus_error_total <= bus_error_total_next;
      held_total      <= held_total_next;
      if (fresh) begin
        have_good <= 1'b1;
      end
    end
  end

  // Store the last good sample
  always_ff @(posedge clk) begin
    if (rst) begin
      good_raw_pressure    <= '0;
      good_raw_temperature <= '0;
      good_pressure        <= '0;
      good_temperature     <= '0;
    end else if (load && fresh) begin
      good_raw_pressure    <= item.first_pressure;
      good_raw_temperature <= item.first_temperature;
      good_pressure        <= conv_pressure;
      good_temperature     <= conv_temperature;
    end
  end

endmodule
